### sv/rbs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and control/status types of the restart backoff scheduler.
// No dependencies; every other file imports this package.
package rbs_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TIME_W      = 48;
    localparam int IDX_W       = 4;
    localparam int ACT_W       = 5;
    localparam int DELAY_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [ACT_W-1:0]   ACTIVE_RST  = ACT_W'(16);
    localparam logic [DATA_W-1:0]  HEALTHY_RST = 32'd60000;
    localparam logic [DATA_W-1:0]  BMIN_RST    = 32'd1000;
    localparam logic [DATA_W-1:0]  BMAX_RST    = 32'd60000;

    typedef enum logic [1:0] {
        REG_ACTIVE  = 2'd0,
        REG_HEALTHY = 2'd1,
        REG_BMIN    = 2'd2,
        REG_BMAX    = 2'd3
    } t_reg_idx;

    typedef enum logic {
        REQ_EXIT = 1'b0,
        REQ_TICK = 1'b1
    } t_req_type;

    typedef enum logic {
        EV_SCHEDULED = 1'b0,
        EV_LAUNCH    = 1'b1
    } t_event_kind;

    typedef struct packed {
        logic [ACT_W-1:0]  active;
        logic [DATA_W-1:0] healthy;
        logic [DATA_W-1:0] bmin;
        logic [DATA_W-1:0] bmax;
    } t_cfg;

    typedef struct packed {
        logic                event_kind;
        logic [IDX_W-1:0]    target_index;
        logic [DELAY_W-1:0]  delay_ms;
        logic [COUNT_W-1:0]  restart_total;
        logic                last_of_run;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load_exit;
        logic load_tick;
        logic ex_start;
        logic back_step;
        logic ex_commit;
        logic launch;
        logic scan_next;
        logic flush;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic exit_ok;
        logic backoff_done;
        logic scan_end;
        logic entry_due;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

### sv/rbs_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on rbs_pkg for field widths.
interface rbs_req_if import rbs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [IDX_W-1:0]  worker_index;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output req_type, output worker_index, output now_ms,
                    input ready);
    modport sink   (input valid, input req_type, input worker_index, input now_ms,
                    output ready);
endinterface

interface rbs_res_if import rbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               event_kind;
    logic [IDX_W-1:0]   target_index;
    logic [DELAY_W-1:0] delay_ms;
    logic [COUNT_W-1:0] restart_total;
    logic               last_of_run;

    modport source (output valid, output event_kind, output target_index, output delay_ms,
                    output restart_total, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input target_index, input delay_ms,
                    input restart_total, input last_of_run, output ready);
endinterface

### sv/rbs_regs.sv
`timescale 1ns / 1ps
// APB configuration register bank of the restart backoff scheduler.
// Depends on rbs_pkg.
module rbs_regs import rbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     wr_en;

    assign reg_sel  = t_reg_idx'(i_paddr[ADDR_W-1:2]);
    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active  <= ACTIVE_RST;
            r_cfg.healthy <= HEALTHY_RST;
            r_cfg.bmin    <= BMIN_RST;
            r_cfg.bmax    <= BMAX_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_ACTIVE:  r_cfg.active  <= i_pwdata[ACT_W-1:0];
                REG_HEALTHY: r_cfg.healthy <= i_pwdata;
                REG_BMIN:    r_cfg.bmin    <= i_pwdata;
                REG_BMAX:    r_cfg.bmax    <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ACTIVE:  o_prdata = {{(DATA_W-ACT_W){1'b0}}, r_cfg.active};
            REG_HEALTHY: o_prdata = r_cfg.healthy;
            REG_BMIN:    o_prdata = r_cfg.bmin;
            REG_BMAX:    o_prdata = r_cfg.bmax;
            default:     o_prdata = '0;
        endcase
    end

endmodule

### sv/rbs_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the restart backoff scheduler: issues datapath commands.
// Depends on rbs_pkg.
module rbs_ctrl import rbs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  logic    i_req_type,
    output logic    o_req_ready,
    input  t_status i_stat,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EX_CHECK,
        S_EX_BACK,
        S_EX_DONE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                // take no item while reset is held
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    if (i_req_type == REQ_TICK) begin
                        o_cmd.load_tick = 1'b1;
                        n_state         = S_SCAN;
                    end else begin
                        o_cmd.load_exit = 1'b1;
                        n_state         = S_EX_CHECK;
                    end
                end
            end
            S_EX_CHECK: begin
                // drop exits of idle or unused workers
                if (i_stat.exit_ok) begin
                    o_cmd.ex_start = 1'b1;
                    n_state        = S_EX_BACK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EX_BACK: begin
                if (i_stat.backoff_done) begin
                    n_state = S_EX_DONE;
                end else begin
                    o_cmd.back_step = 1'b1;
                end
            end
            S_EX_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.ex_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    n_state = S_FLUSH;
                end else if (!i_stat.entry_due) begin
                    o_cmd.scan_next = 1'b1;
                end else if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.launch = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/rbs_dpath.sv
`timescale 1ns / 1ps
// Datapath of the restart backoff scheduler: worker table, backoff unit, result registers.
// Depends on rbs_pkg.
module rbs_dpath import rbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    output t_status           o_stat,
    input  logic [IDX_W-1:0]  i_worker_index,
    input  logic [TIME_W-1:0] i_now_ms,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    // worker table: flags in reset flops, payload qualified by a written bit
    logic [MAX_WORKERS-1:0] r_running;
    logic [MAX_WORKERS-1:0] r_written;
    logic [COUNT_W-1:0]     r_cnt_tab   [MAX_WORKERS];
    logic [TIME_W-1:0]      r_launch_tab[MAX_WORKERS];
    logic [TIME_W-1:0]      r_early_tab [MAX_WORKERS];

    logic [TIME_W-1:0]  r_now;
    logic [ACT_W-1:0]   r_idx;
    logic [RES_W-1:0]   r_nres;
    logic [COUNT_W-1:0] r_cnt_w;
    logic [COUNT_W-1:0] r_iter;
    logic [DELAY_W:0]   r_delay;
    logic               r_pend_valid;
    t_result            r_pend;
    logic               r_out_valid;
    t_result            r_out;

    logic [IDX_W-1:0]   rd_idx;
    logic [COUNT_W-1:0] rd_cnt;
    logic [TIME_W-1:0]  rd_launch;
    logic [TIME_W-1:0]  rd_early;
    logic [ACT_W-1:0]   used;
    logic [TIME_W-1:0]  age;
    logic [COUNT_W-1:0] base_cnt;
    logic [COUNT_W-1:0] new_cnt;
    logic [DELAY_W-1:0] delay_fin;
    logic [TIME_W-1:0]  early_new;
    logic               out_free;

    logic               tab_we;
    logic               tab_running;
    logic [COUNT_W-1:0] tab_cnt;
    logic [TIME_W-1:0]  tab_launch;
    logic [TIME_W-1:0]  tab_early;

    assign rd_idx    = r_idx[IDX_W-1:0];
    assign rd_cnt    = r_written[rd_idx] ? r_cnt_tab[rd_idx]    : '0;
    assign rd_launch = r_written[rd_idx] ? r_launch_tab[rd_idx] : '0;
    assign rd_early  = r_written[rd_idx] ? r_early_tab[rd_idx]  : '0;

    assign used = (i_cfg.active > ACT_W'(MAX_WORKERS)) ? ACT_W'(MAX_WORKERS) : i_cfg.active;

    // run time, modulo the time counter width
    assign age      = r_now - rd_launch;
    assign base_cnt = (age >= {{(TIME_W-DATA_W){1'b0}}, i_cfg.healthy}) ? '0 : rd_cnt;
    assign new_cnt  = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + COUNT_W'(1);

    assign delay_fin = (r_delay > {1'b0, i_cfg.bmax}) ? i_cfg.bmax : r_delay[DELAY_W-1:0];
    assign early_new = r_now + {{(TIME_W-DELAY_W){1'b0}}, delay_fin};
    assign out_free  = !r_out_valid || i_res_ready;

    assign o_stat.exit_ok      = (r_idx < used) && r_running[rd_idx];
    assign o_stat.backoff_done = !((r_iter < r_cnt_w) && (r_delay < {1'b0, i_cfg.bmax})
                                   && (r_delay != '0));
    assign o_stat.scan_end     = (r_idx >= used) || (r_nres >= RES_W'(MAX_RESULTS));
    assign o_stat.entry_due    = !r_running[rd_idx] && (r_now >= rd_early);
    assign o_stat.pend_valid   = r_pend_valid;
    assign o_stat.out_free     = out_free;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        tab_we      = 1'b0;
        tab_running = r_running[rd_idx];
        tab_cnt     = rd_cnt;
        tab_launch  = rd_launch;
        tab_early   = rd_early;
        if (i_cmd.ex_commit) begin
            tab_we      = 1'b1;
            tab_running = 1'b0;
            tab_cnt     = r_cnt_w;
            tab_early   = early_new;
        end else if (i_cmd.launch) begin
            tab_we      = 1'b1;
            tab_running = 1'b1;
            tab_launch  = r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_written <= '0;
        end else if (tab_we) begin
            r_running[rd_idx] <= tab_running;
            r_written[rd_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_cnt_tab[rd_idx]    <= tab_cnt;
            r_launch_tab[rd_idx] <= tab_launch;
            r_early_tab[rd_idx]  <= tab_early;
        end
    end

    // item registers and backoff iteration
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_exit || i_cmd.load_tick) begin
            r_now  <= i_now_ms;
            r_nres <= '0;
            r_idx  <= i_cmd.load_tick ? '0 : {{(ACT_W-IDX_W){1'b0}}, i_worker_index};
        end else begin
            if (i_cmd.launch) begin
                r_nres <= r_nres + RES_W'(1);
            end
            if (i_cmd.launch || i_cmd.scan_next) begin
                r_idx <= r_idx + ACT_W'(1);
            end
        end
        if (i_cmd.ex_start) begin
            r_cnt_w <= new_cnt;
            r_iter  <= COUNT_W'(1);
            r_delay <= {1'b0, i_cfg.bmin};
        end else if (i_cmd.back_step) begin
            r_delay <= {r_delay[DELAY_W-1:0], 1'b0};
            r_iter  <= r_iter + COUNT_W'(1);
        end
    end

    // pending launch result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.ex_commit || i_cmd.flush || (i_cmd.launch && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.launch) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ex_commit) begin
            r_out.event_kind    <= EV_SCHEDULED;
            r_out.target_index  <= rd_idx;
            r_out.delay_ms      <= delay_fin;
            r_out.restart_total <= r_cnt_w;
            r_out.last_of_run   <= 1'b1;
        end else if (i_cmd.flush) begin
            r_out.event_kind    <= r_pend.event_kind;
            r_out.target_index  <= r_pend.target_index;
            r_out.delay_ms      <= r_pend.delay_ms;
            r_out.restart_total <= r_pend.restart_total;
            r_out.last_of_run   <= 1'b1;
        end else if (i_cmd.launch && r_pend_valid) begin
            r_out.event_kind    <= r_pend.event_kind;
            r_out.target_index  <= r_pend.target_index;
            r_out.delay_ms      <= r_pend.delay_ms;
            r_out.restart_total <= r_pend.restart_total;
            r_out.last_of_run   <= 1'b0;
        end
        if (i_cmd.launch) begin
            r_pend.event_kind    <= EV_LAUNCH;
            r_pend.target_index  <= rd_idx;
            r_pend.delay_ms      <= '0;
            r_pend.restart_total <= rd_cnt;
            r_pend.last_of_run   <= 1'b0;
        end
    end

endmodule

### sv/restart_backoff_scheduler.sv
`timescale 1ns / 1ps
// Restart backoff scheduler: top level joining register bank, controller and datapath.
// Depends on rbs_pkg, rbs_if, rbs_regs, rbs_ctrl and rbs_dpath.
//
// The block keeps a sixteen-entry worker table and works on one request item at a time;
// i_req.ready is high only while the controller is idle and reset is released. An exit item
// doubles its backoff delay step by step (at most 32 doublings, bounded by the restart
// count and by the configured maximum, bmax); an exit that is dropped ends at the first check.
// A tick item walks the table one entry per cycle through a single read port, while no
// launch waits on a full output register. Results leave through a one-item output register,
// so a new request is taken while the last result still waits; a tick keeps its newest launch
// back until it knows whether another follows, to mark last_of_run. Any cycle in which a
// result cannot be placed because the output register is still full holds the controller.
// Reset marks every worker idle and due, so the first tick launches all entries in use.
module restart_backoff_scheduler import rbs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbs_req_if.sink           i_req,
    rbs_res_if.source         o_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status stat;
    t_result res;
    logic    req_ready;
    logic    res_valid;

    // configuration; the user must write it only while idle, the block does not enforce it
    rbs_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // sequencing: exit path and tick scan
    rbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table, backoff arithmetic and result registers
    rbs_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_worker_index (i_req.worker_index),
        .i_now_ms       (i_req.now_ms),
        .o_res_valid    (res_valid),
        .i_res_ready    (o_res.ready),
        .o_res          (res)
    );

    assign i_req.ready         = req_ready;
    assign o_res.valid         = res_valid;
    assign o_res.event_kind    = res.event_kind;
    assign o_res.target_index  = res.target_index;
    assign o_res.delay_ms      = res.delay_ms;
    assign o_res.restart_total = res.restart_total;
    assign o_res.last_of_run   = res.last_of_run;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for restart_backoff_scheduler: directed and random exit and tick items,
// register writes between phases, and an in-bench predictor of the worker table.
// Depends on rbs_pkg, rbs_if and the scheduler RTL.
module tb;
    import rbs_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 7;
    // Longest single item: an exit with a full run of doublings.
    localparam int SETTLE_CYCLES = 48;
    localparam int TAIL_CYCLES   = 48;
    localparam int LONG_HOLD     = 600;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    // What the sender does next: offer an item, write a register, or steer the run.
    typedef enum logic [2:0] {
        OP_ITEM,
        OP_CONFIG,
        OP_SYNC,
        OP_HOLD,
        OP_CALM
    } t_plan_kind;

    typedef struct {
        t_plan_kind        kind;
        t_req_type         req;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] now;
        t_reg_idx          reg_sel;
        logic [DATA_W-1:0] value;
    } t_plan_step;

    typedef enum logic [2:0] {
        DRV_FETCH,
        DRV_OFFER,
        DRV_GAP,
        DRV_DRAIN,
        DRV_ACCESS,
        DRV_RELEASE,
        DRV_DONE
    } t_drv_state;

    logic clk = 1'b0;
    logic rst_n;

    rbs_req_if req_ch ();
    rbs_res_if res_ch ();

    logic              apb_psel;
    logic              apb_penable;
    logic              apb_pwrite;
    logic [ADDR_W-1:0] apb_paddr;
    logic [DATA_W-1:0] apb_pwdata;
    logic [DATA_W-1:0] apb_prdata;
    logic              apb_pready;

    restart_backoff_scheduler dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_req     (req_ch),
        .o_res     (res_ch),
        .i_psel    (apb_psel),
        .i_penable (apb_penable),
        .i_pwrite  (apb_pwrite),
        .i_paddr   (apb_paddr),
        .i_pwdata  (apb_pwdata),
        .o_prdata  (apb_prdata),
        .o_pready  (apb_pready)
    );

    always #CLK_HALF_NS clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the worker table
    // ------------------------------------------------------------------
    logic [ACT_W-1:0]   cfg_active;
    logic [DATA_W-1:0]  cfg_healthy;
    logic [DATA_W-1:0]  cfg_bmin;
    logic [DATA_W-1:0]  cfg_bmax;

    logic               w_running  [MAX_WORKERS];
    logic [COUNT_W-1:0] w_count    [MAX_WORKERS];
    logic [TIME_W-1:0]  w_launched [MAX_WORKERS];
    logic [TIME_W-1:0]  w_due_at   [MAX_WORKERS];

    t_result    awaited_results [$];
    t_plan_step plan_steps [$];
    logic [TIME_W-1:0] plan_clock;

    int         fail_count = 0;
    int         cycle_no = 0;
    int         req_taken = 0;
    int         req_sent = 0;
    int         hold_asks = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         stall_left = 0;
    int         gap_left = 0;
    int         settle_left = 0;
    logic       calm = 1'b0;
    t_drv_state drv_state = DRV_FETCH;

    // Delay for a restart count: start at the minimum and double, but stop once the
    // maximum is reached (or the delay is zero), then clamp to the maximum. Keep the
    // doubling 64 bits wide so a minimum above half range does not wrap.
    function automatic logic [DELAY_W-1:0] backoff_for(logic [COUNT_W-1:0] total);
        logic [63:0] span;
        int          k;
        span = {32'd0, cfg_bmin};
        k = 1;
        while (k < total && span < {32'd0, cfg_bmax} && span != 64'd0) begin
            span = span << 1;
            k++;
        end
        if (span > {32'd0, cfg_bmax})
            span = {32'd0, cfg_bmax};
        return span[DELAY_W-1:0];
    endfunction

    // Update the table for one accepted item and queue the results it causes.
    task automatic apply_request(t_req_type kind, logic [IDX_W-1:0] idx,
                                 logic [TIME_W-1:0] now);
        int                used;
        int                launched;
        t_result           res;
        logic [TIME_W-1:0] lived;
        used = (cfg_active > MAX_WORKERS) ? MAX_WORKERS : int'(cfg_active);
        if (kind == REQ_EXIT) begin
            // Ignore exits of idle workers and of entries beyond those in use.
            if (int'(idx) < used && w_running[idx]) begin
                w_running[idx] = 1'b0;
                lived = now - w_launched[idx];
                if (lived >= {16'd0, cfg_healthy})
                    w_count[idx] = '0;
                if (w_count[idx] != COUNT_MAX)
                    w_count[idx] = w_count[idx] + COUNT_W'(1);
                res.event_kind    = EV_SCHEDULED;
                res.target_index  = idx;
                res.delay_ms      = backoff_for(w_count[idx]);
                res.restart_total = w_count[idx];
                res.last_of_run   = 1'b1;
                w_due_at[idx] = now + {16'd0, res.delay_ms};
                awaited_results.push_back(res);
            end
        end else begin
            // Plain unsigned compare: a due time that wrapped past zero is due at once.
            launched = 0;
            for (int i = 0; i < used && launched < MAX_RESULTS; i++) begin
                if (!w_running[i] && now >= w_due_at[i]) begin
                    w_running[i]  = 1'b1;
                    w_launched[i] = now;
                    res.event_kind    = EV_LAUNCH;
                    res.target_index  = IDX_W'(i);
                    res.delay_ms      = '0;
                    res.restart_total = w_count[i];
                    res.last_of_run   = 1'b0;
                    awaited_results.push_back(res);
                    launched++;
                end
            end
            // Mark the final launch of this tick.
            if (launched > 0) begin
                res = awaited_results.pop_back();
                res.last_of_run = 1'b1;
                awaited_results.push_back(res);
            end
        end
    endtask

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------
    task automatic plan_item(t_req_type req, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now);
        t_plan_step s;
        s.kind = OP_ITEM;
        s.req = req;
        s.idx = idx;
        s.now = now;
        s.reg_sel = REG_ACTIVE;
        s.value = '0;
        plan_steps.push_back(s);
    endtask

    task automatic plan_cfg(t_reg_idx reg_sel, logic [DATA_W-1:0] value);
        t_plan_step s;
        s.kind = OP_CONFIG;
        s.req = REQ_TICK;
        s.idx = '0;
        s.now = '0;
        s.reg_sel = reg_sel;
        s.value = value;
        plan_steps.push_back(s);
    endtask

    task automatic plan_mark(t_plan_kind kind);
        t_plan_step s;
        s.kind = kind;
        s.req = REQ_TICK;
        s.idx = '0;
        s.now = '0;
        s.reg_sel = REG_ACTIVE;
        s.value = '0;
        plan_steps.push_back(s);
    endtask

    task automatic plan_phase(logic [DATA_W-1:0] active, logic [DATA_W-1:0] healthy,
                              logic [DATA_W-1:0] bmin, logic [DATA_W-1:0] bmax);
        plan_cfg(REG_ACTIVE, active);
        plan_cfg(REG_HEALTHY, healthy);
        plan_cfg(REG_BMIN, bmin);
        plan_cfg(REG_BMAX, bmax);
    endtask

    // Mostly a believable timeline: time moves forward, exits hit a few favourite
    // workers so counts build up, ticks relaunch whatever is due. A little noise
    // carries a random type, worker and time anywhere in the 48-bit range.
    task automatic plan_random(int n);
        int                roll;
        int                spread;
        logic [TIME_W-1:0] step_ms;
        for (int k = 0; k < n; k++) begin
            spread = $urandom_range(0, 9);
            if (spread < 6)
                step_ms = TIME_W'($urandom_range(0, 1500));
            else if (spread < 9)
                step_ms = TIME_W'($urandom_range(0, 20000));
            else
                step_ms = TIME_W'($urandom_range(0, 200000));
            plan_clock = plan_clock + step_ms;
            roll = $urandom_range(0, 99);
            if (roll < 8)
                plan_item(t_req_type'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 15)),
                          TIME_W'({$urandom, $urandom}));
            else if (roll < 40)
                plan_item(REQ_TICK, IDX_W'($urandom_range(0, 15)), plan_clock);
            else if ($urandom_range(0, 3) == 0)
                plan_item(REQ_EXIT, IDX_W'($urandom_range(0, 15)), plan_clock);
            else
                plan_item(REQ_EXIT, IDX_W'($urandom_range(0, 5)), plan_clock);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offers items and register writes at the falling edge. Work out every
    // next value first, then apply each signal with one nonblocking assignment.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        logic              nv_valid;
        logic              nv_type;
        logic [IDX_W-1:0]  nv_idx;
        logic [TIME_W-1:0] nv_now;
        logic              nv_psel;
        logic              nv_penable;
        logic              nv_pwrite;
        logic [ADDR_W-1:0] nv_paddr;
        logic [DATA_W-1:0] nv_pwdata;
        logic              quiet;
        t_plan_step        cur;
        nv_valid   = req_ch.valid;
        nv_type    = req_ch.req_type;
        nv_idx     = req_ch.worker_index;
        nv_now     = req_ch.now_ms;
        nv_psel    = apb_psel;
        nv_penable = apb_penable;
        nv_pwrite  = apb_pwrite;
        nv_paddr   = apb_paddr;
        nv_pwdata  = apb_pwdata;
        if (rst_n) begin
            // Leave gaps out while bit 7 of the cycle number is set, and entirely near the end.
            quiet = calm || cycle_no[7];

            // Close the access phase of a register write.
            if (drv_state == DRV_RELEASE) begin
                nv_psel    = 1'b0;
                nv_penable = 1'b0;
                drv_state  = DRV_FETCH;
            end
            if (drv_state == DRV_ACCESS) begin
                nv_penable = 1'b1;
                drv_state  = DRV_RELEASE;
            end
            if (drv_state == DRV_GAP) begin
                gap_left--;
                if (gap_left == 0)
                    drv_state = DRV_FETCH;
            end
            // Item taken at the last rising edge: drop valid unless the next item follows.
            if (drv_state == DRV_OFFER && req_taken == req_sent) begin
                nv_valid  = 1'b0;
                drv_state = DRV_FETCH;
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    gap_left  = $urandom_range(1, 5);
                    drv_state = DRV_GAP;
                end
            end
            if (drv_state == DRV_FETCH) begin
                if (plan_steps.size() == 0) begin
                    drv_state = DRV_DONE;
                end else begin
                    case (plan_steps[0].kind)
                        OP_ITEM: begin
                            cur = plan_steps.pop_front();
                            nv_valid  = 1'b1;
                            nv_type   = cur.req;
                            nv_idx    = cur.idx;
                            nv_now    = cur.now;
                            req_sent++;
                            drv_state = DRV_OFFER;
                        end
                        OP_HOLD: begin
                            // Ask the receiver for a long hold-off; keep offering items.
                            cur = plan_steps.pop_front();
                            hold_asks <= hold_asks + 1;
                        end
                        OP_CALM: begin
                            cur = plan_steps.pop_front();
                            calm <= 1'b1;
                        end
                        OP_SYNC: begin
                            // Pause until every awaited result is in.
                            if (awaited_results.size() == 0)
                                cur = plan_steps.pop_front();
                        end
                        default: begin
                            settle_left = SETTLE_CYCLES;
                            drv_state   = DRV_DRAIN;
                        end
                    endcase
                end
            end
            // Write registers only once the block has gone quiet: every result in, then
            // enough cycles for an item that causes no result to finish.
            if (drv_state == DRV_DRAIN) begin
                if (awaited_results.size() != 0) begin
                    settle_left = SETTLE_CYCLES;
                end else if (settle_left > 0) begin
                    settle_left--;
                end else begin
                    cur = plan_steps.pop_front();
                    nv_psel    = 1'b1;
                    nv_penable = 1'b0;
                    nv_pwrite  = 1'b1;
                    nv_paddr   = {cur.reg_sel, 2'b00};
                    nv_pwdata  = cur.value;
                    drv_state  = DRV_ACCESS;
                end
            end
        end
        req_ch.valid        <= nv_valid;
        req_ch.req_type     <= nv_type;
        req_ch.worker_index <= nv_idx;
        req_ch.now_ms       <= nv_now;
        apb_psel            <= nv_psel;
        apb_penable         <= nv_penable;
        apb_pwrite          <= nv_pwrite;
        apb_paddr           <= nv_paddr;
        apb_pwdata          <= nv_pwdata;
    end

    // ------------------------------------------------------------------
    // Receiver: short random stalls, plus one long hold-off on request so the
    // output register fills and the block stops taking items.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD - 1;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (!calm && !cycle_no[6] && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels and the register port at the rising edge.
    // Check results before predicting, so a result leaving as the next item
    // arrives is matched against the older expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_result got;
        t_result want;
        cycle_no <= cycle_no + 1;
        if (rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.event_kind    = res_ch.event_kind;
                got.target_index  = res_ch.target_index;
                got.delay_ms      = res_ch.delay_ms;
                got.restart_total = res_ch.restart_total;
                got.last_of_run   = res_ch.last_of_run;
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with none awaited, actual kind %0d worker %0d",
                             $time, got.event_kind, got.target_index);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("event_kind", want.event_kind, got.event_kind);
                    check_field("target_index", want.target_index, got.target_index);
                    check_field("delay_ms", want.delay_ms, got.delay_ms);
                    check_field("restart_total", want.restart_total, got.restart_total);
                    check_field("last_of_run", want.last_of_run, got.last_of_run);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                apply_request(t_req_type'(req_ch.req_type), req_ch.worker_index,
                              req_ch.now_ms);
                req_taken <= req_taken + 1;
            end
            if (apb_psel && apb_penable && apb_pwrite && apb_pready) begin
                case (t_reg_idx'(apb_paddr[ADDR_W-1:2]))
                    REG_ACTIVE:  cfg_active  = apb_pwdata[ACT_W-1:0];
                    REG_HEALTHY: cfg_healthy = apb_pwdata;
                    REG_BMIN:    cfg_bmin    = apb_pwdata;
                    REG_BMAX:    cfg_bmax    = apb_pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #TIMEOUT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Run control: plan the whole run, reset, then wait for the sender and the
    // awaited results to run dry.
    // ------------------------------------------------------------------
    initial begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.worker_index = '0;
        req_ch.now_ms = '0;
        res_ch.ready = 1'b0;
        apb_psel = 1'b0;
        apb_penable = 1'b0;
        apb_pwrite = 1'b0;
        apb_paddr = '0;
        apb_pwdata = '0;

        cfg_active  = ACTIVE_RST;
        cfg_healthy = HEALTHY_RST;
        cfg_bmin    = BMIN_RST;
        cfg_bmax    = BMAX_RST;
        for (int i = 0; i < MAX_WORKERS; i++) begin
            w_running[i]  = 1'b0;
            w_count[i]    = '0;
            w_launched[i] = '0;
            w_due_at[i]   = '0;
        end

        // Directed part, on reset register values first.
        plan_item(REQ_EXIT, 4'd3, 48'd1000);          // exit of an idle worker
        plan_item(REQ_TICK, 4'hF, 48'd0);             // everything due at reset
        plan_item(REQ_EXIT, 4'd0, 48'd500);           // short run: first backoff
        plan_item(REQ_TICK, 4'hA, 48'd1000);          // nothing due yet
        plan_item(REQ_TICK, 4'd0, 48'd1500);
        plan_item(REQ_EXIT, 4'd0, 48'd2000);          // delay doubles
        plan_item(REQ_TICK, 4'd5, 48'd4000);
        plan_item(REQ_EXIT, 4'd0, 48'd4001);
        plan_item(REQ_EXIT, 4'd15, 48'd100000);       // healthy run clears the count
        plan_item(REQ_EXIT, 4'd15, 48'd100001);       // now idle, dropped
        plan_item(REQ_TICK, 4'd0, TIME_TOP);
        plan_item(REQ_EXIT, 4'd0, TIME_TOP - 48'd255); // restart time wraps past zero
        plan_item(REQ_TICK, 4'd9, TIME_TOP - 48'd254); // wrapped time is due at once
        plan_item(REQ_EXIT, 4'd15, TIME_TOP - 48'd2000);
        plan_item(REQ_TICK, 4'd0, TIME_TOP - 48'd1500); // near the top: still waiting
        plan_item(REQ_TICK, 4'd0, TIME_TOP - 48'd1000);
        plan_cfg(REG_ACTIVE, 32'd4);
        plan_item(REQ_EXIT, 4'd9, 48'd30000);         // entry beyond those in use
        plan_item(REQ_EXIT, 4'd2, 48'd30000);
        plan_cfg(REG_ACTIVE, 32'd0);                  // no entry in use at all
        plan_item(REQ_TICK, 4'd0, TIME_TOP);
        plan_item(REQ_EXIT, 4'd1, 48'd35000);
        plan_cfg(REG_ACTIVE, 32'd31);                 // above the table size
        plan_cfg(REG_BMIN, 32'd0);                    // zero minimum keeps delay at zero
        plan_item(REQ_EXIT, 4'd5, 48'd40000);
        plan_cfg(REG_BMIN, 32'd1000);
        plan_cfg(REG_BMAX, 32'd0);                    // zero maximum forces zero delay
        plan_item(REQ_EXIT, 4'd6, 48'd40000);
        plan_cfg(REG_HEALTHY, 32'd0);                 // every run counts as healthy
        plan_cfg(REG_BMIN, 32'h8000_0001);            // doubling overflows 32 bits
        plan_cfg(REG_BMAX, 32'hFFFF_FFFF);
        plan_item(REQ_EXIT, 4'd7, 48'd50000);
        plan_item(REQ_TICK, 4'd0, 48'd50000);
        plan_cfg(REG_HEALTHY, 32'hFFFF_FFFF);
        plan_item(REQ_EXIT, 4'd5, 48'd60000);
        plan_cfg(REG_ACTIVE, 32'd1);
        plan_item(REQ_EXIT, 4'd0, TIME_TOP);
        plan_item(REQ_TICK, 4'd0, TIME_TOP);

        // Random part, in four register settings.
        plan_clock = 48'd200000;
        plan_phase(32'd16, 32'd60000, 32'd1000, 32'd60000);
        plan_random(40);
        plan_mark(OP_HOLD);
        plan_random(25);
        plan_phase(32'd7, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        plan_random(30);
        plan_mark(OP_SYNC);
        plan_random(35);
        plan_phase(32'd16, 32'd0, 32'd3000, 32'd2000);
        plan_random(40);
        plan_phase(32'd16, 32'd5000, 32'd100, 32'd6400);
        plan_random(25);
        plan_mark(OP_CALM);
        plan_random(40);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        while (drv_state != DRV_DONE)
            @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        // Give any stray result time to show up.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
